@@ rtl/dsa_pkg.sv @@
// Shared types and constants of the disk slot allocator.
package dsa_pkg;

  localparam int unsigned NUM_SLOTS_DEF    = 256;
  localparam int unsigned SECTOR_BYTES_DEF = 512;
  localparam logic [31:0] FIRST_SECTOR_RST = 32'd3;

  // Request opcodes; bit 1 set means locate (codes 2 and 3).
  localparam logic [1:0] OP_ALLOC      = 2'd0;
  localparam logic [1:0] OP_FREE       = 2'd1;
  localparam int unsigned OP_LOCATE_BIT = 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_wr;  // clear the table entry at the sweep address
    logic accept;  // latch a new request, restart the scan
    logic rd;      // read the table entry at the scan address
    logic commit;  // settle the result, update the table
  } dsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_last;   // sweep/scan address is at the last slot
    logic range_fail;  // incoming locate request has an oversized byte range
  } dsa_sts_t;

endpackage

@@ rtl/disk_slot_allocator.sv @@
// Top level of the disk slot allocator: controller plus slot table datapath.
//
// A request is taken when start is high and busy is low. Every request but a
// locate with an oversized byte range scans slots 1 to NUM_SLOTS-1 through
// the single read port of the slot table, one slot per cycle, before the
// done_o strobe; such a locate skips the scan and goes straight to commit.
// Results are shown for exactly one cycle on done_o and cannot be held off;
// a new request may be issued in the cycle done_o is high. After reset the
// table is cleared one slot per cycle, so busy stays high until every slot
// is cleared. The user writes first_sector through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this.
module disk_slot_allocator
  import dsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] owner_id_i,
  input  logic [15:0] byte_start_i,
  input  logic [15:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_o,
  output logic        already_held_o,
  output logic [31:0] sector_o
);

  dsa_cmd_t cmd;
  dsa_sts_t sts;

  dsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dsa_datapath #(
    .NUM_SLOTS    (NUM_SLOTS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .owner_id_i     (owner_id_i),
    .byte_start_i   (byte_start_i),
    .byte_count_i   (byte_count_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .already_held_o (already_held_o),
    .sector_o       (sector_o)
  );

endmodule

@@ rtl/dsa_ctrl.sv @@
// Sequencing controller of the disk slot allocator.
module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dsa_sts_t sts_i,
  output dsa_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.range_fail ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.addr_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // last read word is evaluated at this edge
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ rtl/dsa_datapath.sv @@
// Slot table, scan evaluation and result registers of the disk slot allocator.
module dsa_datapath
  import dsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dsa_cmd_t    cmd_i,
  output dsa_sts_t    sts_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] owner_id_i,
  input  logic [15:0] byte_start_i,
  input  logic [15:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_o,
  output logic        already_held_o,
  output logic [31:0] sector_o
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);

  // Table word: {used, owner}
  logic [16:0]   mem_q [NUM_SLOTS];
  logic [16:0]   rd_data_q;
  logic [AW-1:0] rd_addr_q;
  logic          rd_vld_q;

  logic [AW-1:0] addr_q;
  logic [1:0]    op_q;
  logic [15:0]   id_q;
  logic          range_fail_q;
  logic          hit_q, free_q;
  logic [AW-1:0] hit_slot_q, free_slot_q;
  logic [31:0]   first_sector_q;

  logic          done_q, held_q;
  status_e       status_q;
  logic [7:0]    slot_q;
  logic [31:0]   sector_q;

  logic [16:0]   range_sum;
  status_e       res_status;
  logic [AW-1:0] res_slot;
  logic          res_held;
  logic          res_we;
  logic [16:0]   res_wd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [16:0]   mem_wd;

  assign range_sum        = {1'b0, byte_start_i} + {1'b0, byte_count_i};
  assign sts_o.range_fail = op_i[OP_LOCATE_BIT] && (range_sum > 17'(SECTOR_BYTES));
  assign sts_o.addr_last  = (addr_q == AW'(NUM_SLOTS - 1));

  // Sweep / scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.accept) begin
      addr_q <= AW'(1);  // slot 0 is reserved
    end else if (cmd_i.clr_wr || cmd_i.rd) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // Result decision at commit
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    res_held   = 1'b0;
    res_we     = 1'b0;
    res_wd     = '0;
    if (op_q[OP_LOCATE_BIT]) begin
      if (range_fail_q) begin
        res_status = ST_RANGE;
      end else if (hit_q) begin
        res_status = ST_OK;
        res_slot   = hit_slot_q;
      end
    end else if (op_q == OP_FREE) begin
      if (hit_q) begin
        res_status = ST_OK;
        res_slot   = hit_slot_q;
        res_we     = 1'b1;
      end
    end else begin
      priority if (hit_q) begin
        res_status = ST_OK;
        res_slot   = hit_slot_q;
        res_held   = 1'b1;
      end else if (free_q) begin
        res_status = ST_OK;
        res_slot   = free_slot_q;
        res_we     = 1'b1;
        res_wd     = {1'b1, id_q};
      end else begin
        res_status = ST_FULL;
      end
    end
  end

  assign mem_we = cmd_i.clr_wr || (cmd_i.commit && res_we);
  assign mem_wa = cmd_i.clr_wr ? addr_q : res_slot;
  assign mem_wd = cmd_i.clr_wr ? 17'd0 : res_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[addr_q];
      rd_addr_q <= addr_q;
    end
  end

  // Request and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sector_q <= FIRST_SECTOR_RST;
    end else if (cfg_we_i) begin
      first_sector_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q         <= op_i;
      id_q         <= owner_id_i;
      range_fail_q <= sts_o.range_fail;
    end
  end

  // Scan evaluation: first owner match and first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.accept) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_data_q[16] && (rd_data_q[15:0] == id_q) && !hit_q) hit_q <= 1'b1;
        if (!rd_data_q[16] && !free_q) free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !cmd_i.accept) begin
      if (rd_data_q[16] && (rd_data_q[15:0] == id_q) && !hit_q) hit_slot_q <= rd_addr_q;
      if (!rd_data_q[16] && !free_q) free_slot_q <= rd_addr_q;
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= res_status;
      if (res_status == ST_OK) begin
        slot_q   <= 8'(res_slot);
        held_q   <= res_held;
        sector_q <= first_sector_q + 32'(res_slot);
      end else begin
        slot_q   <= '0;
        held_q   <= 1'b0;
        sector_q <= '0;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign already_held_o = held_q;
  assign sector_o       = sector_q;

endmodule

@@ rtl/dsa_checker.sv @@
// Port-level assertions of the disk slot allocator and their bind.
module dsa_checker
  import dsa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [7:0]  slot_o,
  input logic        already_held_o,
  input logic [31:0] sector_o
);

  // An accepted request keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // A result only follows a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without preceding work");

  // Results are never on two consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // Failed results carry zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (slot_o == 8'd0) && (sector_o == 32'd0)
                                      && !already_held_o)
    else $error("failed result with nonzero payload");

  // already_held only on successful results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && already_held_o |-> (status_o == ST_OK))
    else $error("already_held on failed result");

endmodule

bind disk_slot_allocator dsa_checker u_dsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .slot_o         (slot_o),
  .already_held_o (already_held_o),
  .sector_o       (sector_o)
);

@@ test/disk_slot_allocator_test.sv @@
// Self-checking testbench of the disk slot allocator: directed table, random phases, scoreboard.
module disk_slot_allocator_test;
  import dsa_pkg::*;

  localparam int unsigned SLOTS     = NUM_SLOTS_DEF;
  localparam int unsigned SECT_SIZE = SECTOR_BYTES_DEF;
  // Any op with bit 1 set is a locate; both codes are driven.
  localparam logic [1:0]  OP_LOCATE     = 2'd2;
  localparam logic [1:0]  OP_LOCATE_ALT = 2'd3;
  localparam logic [31:0] SECTOR_TOP    = 32'hFFFF_FF00;
  localparam int          N_DIRECTED    = 20;
  localparam int          POOL_DEPTH    = 320;
  // Settling margin, longer than one request takes.
  localparam int          SETTLE_CYCLES = SLOTS + 44;

  typedef struct packed {
    status_e     status;
    logic [7:0]  slot;
    logic        held;
    logic [31:0] sector;
  } slot_answer_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [15:0]  id;
    logic [15:0]  bstart;
    logic [15:0]  bcount;
    logic         typed;   // answer below is used instead of the prediction
    slot_answer_t answer;
  } request_row_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [1:0]  op_i         = OP_ALLOC;
  logic [15:0] owner_id_i   = '0;
  logic [15:0] byte_start_i = '0;
  logic [15:0] byte_count_i = '0;
  logic        cfg_we_i     = 1'b0;
  logic [31:0] cfg_wdata_i  = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  slot_o;
  logic        already_held_o;
  logic [31:0] sector_o;

  disk_slot_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .owner_id_i     (owner_id_i),
    .byte_start_i   (byte_start_i),
    .byte_count_i   (byte_count_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .already_held_o (already_held_o),
    .sector_o       (sector_o)
  );

  // Shadow of the slot table and of first_sector.
  logic        shadow_used  [SLOTS];
  logic [15:0] shadow_owner [SLOTS];
  logic [31:0] shadow_first_sector;

  slot_answer_t pending_answers [$];
  logic [15:0]  id_pool [POOL_DEPTH];

  int error_count;
  int n_alloc, n_free, n_locate, n_op3;
  int n_ok, n_held, n_full, n_not_found, n_range;

  // Directed requests, reset value of first_sector (3) in force.
  // Rows with typed = 0 are left to the predictor.
  request_row_t directed_rows [N_DIRECTED] = '{
    // free slot with owner zero must not match id 0
    '{OP_LOCATE,     16'h0000, 16'd0,     16'd0,     1'b1, '{ST_NOT_FOUND, 8'd0, 1'b0, 32'd0}},
    '{OP_FREE,       16'h0000, 16'd0,     16'd0,     1'b1, '{ST_NOT_FOUND, 8'd0, 1'b0, 32'd0}},
    '{OP_ALLOC,      16'h0000, 16'd0,     16'd0,     1'b1, '{ST_OK,        8'd1, 1'b0, 32'd4}},
    '{OP_ALLOC,      16'h0000, 16'd0,     16'd0,     1'b1, '{ST_OK,        8'd1, 1'b1, 32'd4}},
    '{OP_ALLOC,      16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b1, '{ST_OK,        8'd2, 1'b0, 32'd5}},
    // whole sector fits, one byte more does not
    '{OP_LOCATE,     16'hFFFF, 16'd0,     16'd512,   1'b1, '{ST_OK,        8'd2, 1'b0, 32'd5}},
    '{OP_LOCATE,     16'hFFFF, 16'd1,     16'd512,   1'b1, '{ST_RANGE,     8'd0, 1'b0, 32'd0}},
    // range check comes before the search
    '{OP_LOCATE,     16'h1234, 16'hFFFF,  16'hFFFF,  1'b1, '{ST_RANGE,     8'd0, 1'b0, 32'd0}},
    '{OP_LOCATE_ALT, 16'hFFFF, 16'd511,   16'd1,     1'b1, '{ST_OK,        8'd2, 1'b0, 32'd5}},
    '{OP_FREE,       16'h0000, 16'd0,     16'd0,     1'b1, '{ST_OK,        8'd1, 1'b0, 32'd4}},
    '{OP_ALLOC,      16'h00AA, 16'd0,     16'd0,     1'b1, '{ST_OK,        8'd1, 1'b0, 32'd4}},
    '{OP_LOCATE,     16'h0000, 16'd512,   16'd0,     1'b1, '{ST_NOT_FOUND, 8'd0, 1'b0, 32'd0}},
    '{OP_ALLOC,      16'h5A5A, 16'h8000,  16'h0001,  1'b0, '{ST_OK,        8'd0, 1'b0, 32'd0}},
    '{OP_ALLOC,      16'h00AA, 16'd0,     16'd0,     1'b0, '{ST_OK,        8'd0, 1'b0, 32'd0}},
    '{OP_FREE,       16'hFFFF, 16'd0,     16'd0,     1'b1, '{ST_OK,        8'd2, 1'b0, 32'd5}},
    '{OP_FREE,       16'hFFFF, 16'd0,     16'd0,     1'b1, '{ST_NOT_FOUND, 8'd0, 1'b0, 32'd0}},
    '{OP_ALLOC,      16'h8001, 16'h7FFF,  16'h8000,  1'b0, '{ST_OK,        8'd0, 1'b0, 32'd0}},
    '{OP_LOCATE_ALT, 16'h5A5A, 16'h0100,  16'h0100,  1'b0, '{ST_OK,        8'd0, 1'b0, 32'd0}},
    '{OP_FREE,       16'h00AA, 16'd0,     16'd0,     1'b0, '{ST_OK,        8'd0, 1'b0, 32'd0}},
    '{OP_LOCATE,     16'h8000, 16'd0,     16'd0,     1'b1, '{ST_NOT_FOUND, 8'd0, 1'b0, 32'd0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TIMEOUT: %0d answers still pending", pending_answers.size());
    $display("disk_slot_allocator_test NOT OK");
    $finish;
  end

  // Answer of the slot table to one request; updates the shadow table.
  function automatic slot_answer_t slot_table_answer(input logic [1:0] op,
                                                     input logic [15:0] id,
                                                     input logic [15:0] bstart,
                                                     input logic [15:0] bcount);
    slot_answer_t ans;
    int hit;
    int lowest_free;
    int pick;
    ans = '{ST_OK, 8'd0, 1'b0, 32'd0};
    hit = 0;
    lowest_free = 0;
    pick = 0;
    // slot 0 is reserved: scan from the top down to 1 so the lowest wins
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (shadow_used[i] && shadow_owner[i] == id) hit = i;
      if (!shadow_used[i]) lowest_free = i;
    end
    if (op[OP_LOCATE_BIT]) begin
      if (int'(bstart) + int'(bcount) > int'(SECT_SIZE)) ans.status = ST_RANGE;
      else if (hit == 0) ans.status = ST_NOT_FOUND;
      else pick = hit;
    end else if (op == OP_FREE) begin
      if (hit == 0) begin
        ans.status = ST_NOT_FOUND;
      end else begin
        pick = hit;
        shadow_used[hit]  = 1'b0;
        shadow_owner[hit] = '0;
      end
    end else begin
      if (hit != 0) begin
        pick = hit;
        ans.held = 1'b1;
      end else if (lowest_free != 0) begin
        pick = lowest_free;
        shadow_used[lowest_free]  = 1'b1;
        shadow_owner[lowest_free] = id;
      end else begin
        ans.status = ST_FULL;
      end
    end
    if (ans.status == ST_OK) begin
      ans.slot   = pick[7:0];
      ans.sector = shadow_first_sector + 32'(pick);
    end
    return ans;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Scoreboard: every done_o strobe is matched against the oldest answer.
  always @(posedge clk_i) begin
    slot_answer_t want;
    if (rst_ni && done_o) begin
      case (status_o)
        ST_OK:        n_ok++;
        ST_FULL:      n_full++;
        ST_NOT_FOUND: n_not_found++;
        default:      n_range++;
      endcase
      if (status_o == ST_OK && already_held_o) n_held++;
      if (pending_answers.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (slot_o !== want.slot)
          flag_mismatch($sformatf("slot %0d, expected %0d", slot_o, want.slot));
        if (already_held_o !== want.held)
          flag_mismatch($sformatf("already_held %b, expected %b", already_held_o, want.held));
        if (sector_o !== want.sector)
          flag_mismatch($sformatf("sector %h, expected %h", sector_o, want.sector));
      end
    end
  end

  // Present one request and hold it until busy is low at a clock edge.
  // start is left high; the caller lowers it only when it wants a gap.
  task automatic issue_request(input logic [1:0] op, input logic [15:0] id,
                               input logic [15:0] bstart, input logic [15:0] bcount,
                               input logic typed, input slot_answer_t typed_answer);
    slot_answer_t predicted;
    start        <= 1'b1;
    op_i         <= op;
    owner_id_i   <= id;
    byte_start_i <= bstart;
    byte_count_i <= bcount;
    do @(posedge clk_i); while (busy);
    predicted = slot_table_answer(op, id, bstart, bcount);
    pending_answers.push_back(typed ? typed_answer : predicted);
    if (op[OP_LOCATE_BIT]) begin
      n_locate++;
      if (op == OP_LOCATE_ALT) n_op3++;
    end else if (op == OP_FREE) begin
      n_free++;
    end else begin
      n_alloc++;
    end
  endtask

  // Stop sending and wait for every outstanding answer.
  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // first_sector may only change while the table is idle.
  task automatic write_first_sector(input logic [31:0] value);
    drain_answers();
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_first_sector = value;
  endtask

  // Random phase. walk_allocs steps allocations through the id pool in order,
  // which fills the table and drives it into the full case.
  task automatic run_phase(input int n_items, input int idle_pct, input int pool_n,
                           input bit new_pool, input bit walk_allocs,
                           input int alloc_w, input int free_w, input bit drain_pauses);
    int          r;
    int          walk_idx;
    int          gap;
    logic [1:0]  op;
    logic [15:0] id;
    logic [15:0] bs;
    logic [15:0] bc;
    walk_idx = 0;
    if (new_pool) begin
      for (int i = 0; i < POOL_DEPTH; i++) id_pool[i] = 16'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
    end
    for (int n = 0; n < n_items; n++) begin
      if (drain_pauses && $urandom_range(0, 39) == 0) begin
        drain_answers();
      end else if (int'($urandom_range(0, 99)) < idle_pct) begin
        // mostly short gaps, some long enough to land anywhere in a scan
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 300) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      r  = $urandom_range(0, 99);
      bs = 16'($urandom);
      bc = 16'($urandom);
      id = id_pool[$urandom_range(0, pool_n - 1)];
      if (r < alloc_w) begin
        op = OP_ALLOC;
        if (walk_allocs) begin
          id = id_pool[walk_idx % pool_n];
          walk_idx++;
        end
      end else if (r < alloc_w + free_w) begin
        op = OP_FREE;
      end else begin
        op = ($urandom_range(0, 3) == 0) ? OP_LOCATE_ALT : OP_LOCATE;
        if ($urandom_range(0, 99) < 85) begin
          bs = 16'($urandom_range(0, SECT_SIZE));
          bc = 16'($urandom_range(0, SECT_SIZE - bs));
        end
      end
      if ($urandom_range(0, 9) == 0) id = 16'($urandom);
      issue_request(op, id, bs, bc, 1'b0, '0);
    end
  endtask

  initial begin
    int settle;
    error_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i]  = 1'b0;
      shadow_owner[i] = '0;
    end
    shadow_first_sector = FIRST_SECTOR_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; the first request also waits out the clearing sweep
    for (int k = 0; k < N_DIRECTED; k++)
      issue_request(directed_rows[k].op, directed_rows[k].id, directed_rows[k].bstart,
                    directed_rows[k].bcount, directed_rows[k].typed,
                    directed_rows[k].answer);

    write_first_sector(32'd0);
    run_phase(350, 0, 24, 1'b1, 1'b0, 40, 30, 1'b0);

    write_first_sector(SECTOR_TOP);
    run_phase(450, 68, POOL_DEPTH, 1'b1, 1'b1, 80, 5, 1'b0);

    // same pool as the fill phase, free-heavy to empty the table again
    write_first_sector(32'($urandom_range(0, SECTOR_TOP)));
    run_phase(400, 28, POOL_DEPTH, 1'b0, 1'b0, 15, 60, 1'b0);

    write_first_sector(32'($urandom_range(0, SECTOR_TOP)));
    run_phase(500, 0, 8, 1'b1, 1'b0, 40, 30, 1'b1);

    start <= 1'b0;
    settle = 0;
    while (pending_answers.size() != 0 && settle < 4 * SETTLE_CYCLES) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0)
      flag_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

    $display("Covered %0d requests: %0d allocate, %0d free, %0d locate (%0d with op 3)",
             n_alloc + n_free + n_locate, n_alloc, n_free, n_locate, n_op3);
    $display("Seen %0d ok (%0d already held), %0d table full, %0d not found, %0d bad range",
             n_ok, n_held, n_full, n_not_found, n_range);
    if (error_count == 0) begin
      $display("disk_slot_allocator_test OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("disk_slot_allocator_test NOT OK");
    end
    $finish;
  end

endmodule
